### src/dpf_pkg.sv
package dpf_pkg;

  // Number formats
  localparam int FRAC_BITS  = 16;
  localparam int DIR_BITS   = 28;

  // Depth of the iterative units, one result bit per stage
  localparam int SQRT_STAGES = 31;
  localparam int DIV_STAGES  = 35;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 3'd0,
    CFG_CENTER_Y = 3'd1,
    CFG_CENTER_Z = 3'd2,
    CFG_MOMENT_X = 3'd3,
    CFG_MOMENT_Y = 3'd4,
    CFG_MOMENT_Z = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_t;

  typedef struct packed {
    logic signed [47:0] field_x;
    logic signed [47:0] field_y;
    logic signed [47:0] field_z;
    logic signed [47:0] potential;
    logic               singular;
    logic               overflow;
  } out_t;

endpackage

### src/dpf_isqrt.sv
// Pipelined integer square root, two radicand bits per stage
module dpf_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] rad_i,
  output logic [30:0] root_o
);

  localparam int NST = dpf_pkg::SQRT_STAGES;

  logic [32:0] rem_q  [NST-1];
  logic [61:0] rad_q  [NST-1];
  logic [30:0] root_q [NST];

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic [32:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] rad_in;
    logic [34:0] trial_rem;
    logic [34:0] trial;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
      assign rad_in  = rad_q[i-1];
    end

    // Bring down two bits, try 4*root+1
    assign trial_rem = {rem_in, rad_in[61:60]};
    assign trial     = {2'b00, root_in, 2'b01};
    assign ge        = trial_rem >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[i] <= {root_in[29:0], ge};
      end
    end

    if (i < NST - 1) begin : g_carry
      logic [34:0] diff;
      assign diff = trial_rem - trial;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= ge ? diff[32:0] : trial_rem[32:0];
          rad_q[i] <= {rad_in[59:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[NST-1];

endmodule

### src/dpf_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// The quotient must fit in 35 bits.
module dpf_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [62:0] num_i,
  input  logic [30:0] den_i,
  output logic [34:0] quo_o
);

  localparam int NST = dpf_pkg::DIV_STAGES;

  logic [30:0] rem_q [NST-1];
  logic [30:0] den_q [NST-1];
  logic [34:0] w_q   [NST];

  for (genvar i = 0; i < NST; i++) begin : g_stage
    logic [30:0] rem_in;
    logic [30:0] den_in;
    logic [34:0] w_in;
    logic [31:0] t;
    logic        ge;

    if (i == 0) begin : g_first
      assign rem_in = {3'b000, num_i[62:35]};
      assign den_in = den_i;
      assign w_in   = num_i[34:0];
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign w_in   = w_q[i-1];
    end

    // Shift in the next dividend bit and try a subtract
    assign t  = {rem_in, w_in[34]};
    assign ge = t >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[i] <= {w_in[33:0], ge};
      end
    end

    if (i < NST - 1) begin : g_carry
      logic [31:0] diff;
      assign diff = t - {1'b0, den_in};
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[i] <= ge ? diff[30:0] : t[30:0];
          den_q[i] <= den_in;
        end
      end
    end
  end

  assign quo_o = w_q[NST-1];

endmodule

### src/dipole_field_and_potential.sv
// Point dipole evaluator: field and potential at a stream of test points.
// Input channel: one test point (Q16.16) per beat, valid/ready.
// Output channel: field x/y/z and potential (Q32.16, saturated), plus
// singular and overflow flags, one beat per input beat, in order.
// Configuration: write enable, register index and 32-bit data. The user must
// write center and moment only while no point is in flight; the block does
// not enforce this. Indexes 6 and 7 are dropped. Throughput: one point per
// cycle while the pipeline is not stalled. Most of the depth comes from the
// square root (31 stages), the unit-vector divide (35 stages) and three chained
// divides by the distance (105 stages), each resolving one bit per stage.
// Reset clears the configuration registers to zero and empties the pipeline.
// Stall: the whole pipeline holds while an output beat waits and the
// receiver is not ready; ready on the input follows that same condition.
module dipole_field_and_potential (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  dpf_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output dpf_pkg::out_t                       out_data_o,
  input  logic                                cfg_we_i,
  input  logic [dpf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dpf_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int SQ       = dpf_pkg::SQRT_STAGES;
  localparam int DV       = dpf_pkg::DIV_STAGES;
  localparam int MID_LEN  = 11;
  localparam int RND_LEN  = 3 * DV;
  localparam int PIPE_LEN = 6 + SQ + DV + MID_LEN + RND_LEN + 3;
  localparam int FB       = dpf_pkg::FRAC_BITS;
  localparam int DB       = dpf_pkg::DIR_BITS;
  localparam logic signed [8:0] OFF_FIELD = 9'(3 * (FB - DB));
  localparam logic signed [8:0] OFF_POT   = 9'(2 * (FB - DB));

  typedef struct packed {
    logic [2:0][29:0]   rs;
    logic signed [6:0]  e;
    logic               sing;
    logic [2:0]         rneg;
  } sqd_t;

  typedef struct packed {
    logic [30:0]        n;
    logic signed [6:0]  e;
    logic               sing;
    logic [2:0]         rneg;
  } hd_t;

  typedef struct packed {
    logic [30:0]        n;
    logic signed [6:0]  e;
    logic               sing;
  } mid_t;

  typedef struct packed {
    logic [30:0]        n;
    logic signed [6:0]  e;
    logic               sing;
    logic [3:0][5:0]    z;
    logic [3:0]         neg;
    logic [3:0]         zero;
  } rnd_t;

  logic en;
  logic [PIPE_LEN-1:0] vld_q;

  logic [2:0][31:0] center_q;
  logic [2:0][31:0] moment_q;

  // Advance whenever the output slot is free or being taken
  assign en          = !vld_q[PIPE_LEN-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[PIPE_LEN-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LEN-2:0], in_valid_i};
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= '0;
      moment_q <= '0;
    end else if (cfg_we_i) begin
      case (dpf_pkg::cfg_idx_e'(cfg_idx_i))
        dpf_pkg::CFG_CENTER_X: center_q[0] <= cfg_data_i;
        dpf_pkg::CFG_CENTER_Y: center_q[1] <= cfg_data_i;
        dpf_pkg::CFG_CENTER_Z: center_q[2] <= cfg_data_i;
        dpf_pkg::CFG_MOMENT_X: moment_q[0] <= cfg_data_i;
        dpf_pkg::CFG_MOMENT_Y: moment_q[1] <= cfg_data_i;
        dpf_pkg::CFG_MOMENT_Z: moment_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Front: offset, magnitude, range shift, squares
  // ---------------------------------------------------------------
  logic [2:0][31:0] pt;
  logic [2:0][32:0] r_d, rm_a_d;
  logic [2:0][32:0] rm_a_q, rm_b_q, rm_c_q;
  logic [2:0]       rneg_a_q, rneg_b_q, rneg_c_q, rneg_d_q, rneg_e_q, rneg_f_q;
  logic [32:0]      a_d, a_b_q;
  logic [5:0]       msb_d, msb_c_q;
  logic             sing_c_q, sing_d_q, sing_e_q, sing_f_q;
  logic [2:0][29:0] rs_d, rs_d_q, rs_e_q, rs_f_q;
  logic signed [6:0] e_d, e_d_q, e_e_q, e_f_q;
  logic [2:0][59:0] sq_d, sq_e_q;
  logic [61:0]      s_d, s_f_q;

  assign pt = {in_data_i.point_z, in_data_i.point_y, in_data_i.point_x};

  // Offset from center and its magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_d[i]    = {pt[i][31], pt[i]} - {center_q[i][31], center_q[i]};
      rm_a_d[i] = r_d[i][32] ? 33'(-r_d[i]) : r_d[i];
    end
  end

  // Largest magnitude
  always_comb begin
    a_d = rm_a_q[0];
    if (rm_a_q[1] > a_d) a_d = rm_a_q[1];
    if (rm_a_q[2] > a_d) a_d = rm_a_q[2];
  end

  // Leading one of the largest magnitude
  always_comb begin
    msb_d = '0;
    for (int b = 0; b < 33; b++) begin
      if (a_b_q[b]) msb_d = 6'(b);
    end
  end

  // Move the largest magnitude into [2^29, 2^30)
  always_comb begin
    e_d = $signed(7'd29) - $signed({1'b0, msb_c_q});
    for (int i = 0; i < 3; i++) begin
      logic [32:0] sh;
      sh = (msb_c_q > 6'd29) ? (rm_c_q[i] >> (msb_c_q - 6'd29))
                             : (rm_c_q[i] << (6'd29 - msb_c_q));
      rs_d[i] = sh[29:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = rs_d_q[i] * rs_d_q[i];
    end
    s_d = {2'b00, sq_e_q[0]} + {2'b00, sq_e_q[1]} + {2'b00, sq_e_q[2]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rneg_a_q[i] <= r_d[i][32];
      end
      rm_a_q   <= rm_a_d;
      rm_b_q   <= rm_a_q;
      rneg_b_q <= rneg_a_q;
      a_b_q    <= a_d;
      rm_c_q   <= rm_b_q;
      rneg_c_q <= rneg_b_q;
      msb_c_q  <= msb_d;
      sing_c_q <= (a_b_q == '0);
      rs_d_q   <= rs_d;
      e_d_q    <= e_d;
      rneg_d_q <= rneg_c_q;
      sing_d_q <= sing_c_q;
      sq_e_q   <= sq_d;
      rs_e_q   <= rs_d_q;
      e_e_q    <= e_d_q;
      rneg_e_q <= rneg_d_q;
      sing_e_q <= sing_d_q;
      s_f_q    <= s_d;
      rs_f_q   <= rs_e_q;
      e_f_q    <= e_e_q;
      rneg_f_q <= rneg_e_q;
      sing_f_q <= sing_e_q;
    end
  end

  // ---------------------------------------------------------------
  // Distance: square root of the sum of squares
  // ---------------------------------------------------------------
  logic [30:0] n_w;
  sqd_t        sqd_q [SQ];

  dpf_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s_f_q),
    .root_o (n_w)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqd_q[0] <= '{rs: rs_f_q, e: e_f_q, sing: sing_f_q, rneg: rneg_f_q};
      for (int k = 1; k < SQ; k++) begin
        sqd_q[k] <= sqd_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Unit vector: h = r * 2^28 / n
  // ---------------------------------------------------------------
  logic [2:0][34:0] hm_w;
  hd_t              hd_q [DV];

  for (genvar i = 0; i < 3; i++) begin : g_hdiv
    dpf_div u_hdiv (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i ({5'b00000, sqd_q[SQ-1].rs[i], 28'b0}),
      .den_i (n_w),
      .quo_o (hm_w[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hd_q[0] <= '{n: n_w, e: sqd_q[SQ-1].e, sing: sqd_q[SQ-1].sing,
                   rneg: sqd_q[SQ-1].rneg};
      for (int k = 1; k < DV; k++) begin
        hd_q[k] <= hd_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Projection c, field numerators u, normalize
  // ---------------------------------------------------------------
  mid_t              mid_q [MID_LEN];
  logic [2:0][29:0]  hv_d;
  logic [2:0][29:0]  hv_q [5];
  logic [2:0][61:0]  dp_d, dp_q;
  logic signed [63:0] dot_d, dot_q, dadj;
  logic [33:0]       c_d;
  logic [33:0]       cq [5];
  logic signed [35:0] c3_d, c3_q;
  logic [2:0][65:0]  pr_d, pr_q;
  logic [2:0][37:0]  t_d, t_q, u_d, u_q;
  logic [3:0][37:0]  x_w;
  logic [3:0][34:0]  mag_d, mag_o_q, mag_p_q, qn_d, qn_q;
  logic [3:0]        neg_o_q, neg_p_q, neg_w_q, zero_o_q, zero_p_q, zero_w_q;
  logic [3:0][5:0]   msb4_d, msb4_q, z_d, z_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hv_d[i] = hd_q[DV-1].rneg[i] ? 30'(-hm_w[i][29:0]) : hm_w[i][29:0];
      dp_d[i] = $signed(moment_q[i]) * $signed(hv_q[0][i]);
    end
    dot_d = $signed(dp_q[0]) + $signed(dp_q[1]) + $signed(dp_q[2]);
    // Truncate toward zero on the 2^28 scale
    dadj  = dot_q + $signed({36'b0, {28{dot_q[63]}}});
    c_d   = dadj[61:28];
    c3_d  = $signed(cq[0]) + $signed({cq[0], 1'b0});
    for (int i = 0; i < 3; i++) begin
      logic signed [65:0] padj;
      pr_d[i] = $signed(c3_q) * $signed(hv_q[4][i]);
      padj    = $signed(pr_q[i]) + $signed({38'b0, {28{pr_q[i][65]}}});
      t_d[i]  = padj[65:28];
      u_d[i]  = $signed(t_q[i]) - $signed(moment_q[i]);
    end
  end

  // Lanes: three field components, then the potential
  assign x_w = {{{4{cq[4][33]}}, cq[4]}, u_q[2], u_q[1], u_q[0]};

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [37:0] m;
      m        = x_w[j][37] ? 38'(-x_w[j]) : x_w[j];
      mag_d[j] = m[34:0];
      msb4_d[j] = '0;
      for (int b = 0; b < 35; b++) begin
        if (mag_o_q[j][b]) msb4_d[j] = 6'(b);
      end
      z_d[j]  = (msb4_q[j] >= 6'd34) ? 6'd0 : 6'd34 - msb4_q[j];
      qn_d[j] = mag_p_q[j] << z_d[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_q[0] <= '{n: hd_q[DV-1].n, e: hd_q[DV-1].e, sing: hd_q[DV-1].sing};
      for (int k = 1; k < MID_LEN; k++) begin
        mid_q[k] <= mid_q[k-1];
      end
      hv_q[0] <= hv_d;
      for (int k = 1; k < 5; k++) begin
        hv_q[k] <= hv_q[k-1];
      end
      dp_q  <= dp_d;
      dot_q <= dot_d;
      cq[0] <= c_d;
      for (int k = 1; k < 5; k++) begin
        cq[k] <= cq[k-1];
      end
      c3_q <= c3_d;
      pr_q <= pr_d;
      t_q  <= t_d;
      u_q  <= u_d;
      for (int j = 0; j < 4; j++) begin
        neg_o_q[j]  <= x_w[j][37];
        zero_o_q[j] <= (x_w[j] == '0);
      end
      mag_o_q  <= mag_d;
      msb4_q   <= msb4_d;
      mag_p_q  <= mag_o_q;
      neg_p_q  <= neg_o_q;
      zero_p_q <= zero_o_q;
      qn_q     <= qn_d;
      z_q      <= z_d;
      neg_w_q  <= neg_p_q;
      zero_w_q <= zero_p_q;
    end
  end

  // ---------------------------------------------------------------
  // Repeated divides by the distance
  // ---------------------------------------------------------------
  rnd_t             sc_q [RND_LEN];
  logic [34:0]      dly3_q [DV];
  logic [2:0][34:0] quo1, quo2, quo3;
  logic [34:0]      quo_pa, quo_pb;

  for (genvar i = 0; i < 3; i++) begin : g_fdiv
    dpf_div u_div1 (
      .clk_i (clk_i), .en_i (en),
      .num_i ({qn_q[i], 28'b0}), .den_i (mid_q[MID_LEN-1].n), .quo_o (quo1[i])
    );
    dpf_div u_div2 (
      .clk_i (clk_i), .en_i (en),
      .num_i ({quo1[i], 28'b0}), .den_i (sc_q[DV-1].n), .quo_o (quo2[i])
    );
    dpf_div u_div3 (
      .clk_i (clk_i), .en_i (en),
      .num_i ({quo2[i], 28'b0}), .den_i (sc_q[2*DV-1].n), .quo_o (quo3[i])
    );
  end

  // Potential takes two divides, started one divide later
  dpf_div u_pdiv1 (
    .clk_i (clk_i), .en_i (en),
    .num_i ({dly3_q[DV-1], 28'b0}), .den_i (sc_q[DV-1].n), .quo_o (quo_pa)
  );
  dpf_div u_pdiv2 (
    .clk_i (clk_i), .en_i (en),
    .num_i ({quo_pa, 28'b0}), .den_i (sc_q[2*DV-1].n), .quo_o (quo_pb)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sc_q[0] <= '{n: mid_q[MID_LEN-1].n, e: mid_q[MID_LEN-1].e,
                   sing: mid_q[MID_LEN-1].sing, z: z_q, neg: neg_w_q, zero: zero_w_q};
      for (int k = 1; k < RND_LEN; k++) begin
        sc_q[k] <= sc_q[k-1];
      end
      dly3_q[0] <= qn_q[3];
      for (int k = 1; k < DV; k++) begin
        dly3_q[k] <= dly3_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Binary placement, saturation, sign
  // ---------------------------------------------------------------
  logic signed [8:0] e9;
  logic signed [8:0] sh_d [4];
  logic signed [8:0] sh_r_q [4];
  logic [3:0][34:0]  mag_r_q;
  logic [3:0]        neg_r_q, zero_r_q, neg_s_q, zero_s_q;
  logic              sing_r_q, sing_s_q;
  logic [3:0][47:0]  val_d, val_q;
  logic [3:0]        sat_d, sat_q;
  logic [3:0][47:0]  res_d;
  dpf_pkg::out_t     out_q;

  assign e9 = {{2{sc_q[RND_LEN-1].e[6]}}, sc_q[RND_LEN-1].e};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sh_d[j] = e9 + e9 + e9 + OFF_FIELD - $signed({3'b000, sc_q[RND_LEN-1].z[j]});
    end
    sh_d[3] = e9 + e9 + OFF_POT - $signed({3'b000, sc_q[RND_LEN-1].z[3]});
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      logic [47:0] lim;
      logic [82:0] wide;
      logic [8:0]  nsh;
      lim      = neg_r_q[j] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      wide     = {48'b0, mag_r_q[j]} << sh_r_q[j][5:0];
      nsh      = 9'(-sh_r_q[j]);
      sat_d[j] = 1'b0;
      val_d[j] = '0;
      if (!sh_r_q[j][8]) begin
        if (sh_r_q[j][7:0] >= 8'd48 || wide > {35'b0, lim}) begin
          sat_d[j] = 1'b1;
          val_d[j] = lim;
        end else begin
          val_d[j] = wide[47:0];
        end
      end else if (nsh[6:0] < 7'd35) begin
        val_d[j] = {13'b0, mag_r_q[j] >> nsh[5:0]};
      end
      res_d[j] = (zero_s_q[j] || sing_s_q) ? 48'd0
               : (neg_s_q[j] ? 48'(-val_q[j]) : val_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_r_q  <= {quo_pb, quo3[2], quo3[1], quo3[0]};
      for (int j = 0; j < 4; j++) begin
        sh_r_q[j] <= sh_d[j];
      end
      neg_r_q  <= sc_q[RND_LEN-1].neg;
      zero_r_q <= sc_q[RND_LEN-1].zero;
      sing_r_q <= sc_q[RND_LEN-1].sing;
      val_q    <= val_d;
      sat_q    <= sat_d;
      neg_s_q  <= neg_r_q;
      zero_s_q <= zero_r_q;
      sing_s_q <= sing_r_q;
      out_q.field_x   <= res_d[0];
      out_q.field_y   <= res_d[1];
      out_q.field_z   <= res_d[2];
      out_q.potential <= res_d[3];
      out_q.singular  <= sing_s_q;
      out_q.overflow  <= (|(sat_q & ~zero_s_q)) && !sing_s_q;
    end
  end

  assign out_data_o = out_q;

endmodule

### src/dpf_checker.sv
module dpf_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready_o,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input dpf_pkg::out_t out_data_o
);

  // A singular point gives all-zero values and no overflow
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |->
      out_data_o.field_x == '0 && out_data_o.field_y == '0 &&
      out_data_o.field_z == '0 && out_data_o.potential == '0 &&
      !out_data_o.overflow)
    else $error("singular beat carries nonzero values");

  // Overflow means some value sits at a bound
  a_overflow_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      out_data_o.field_x == 48'h7FFF_FFFF_FFFF || out_data_o.field_x == 48'h8000_0000_0000 ||
      out_data_o.field_y == 48'h7FFF_FFFF_FFFF || out_data_o.field_y == 48'h8000_0000_0000 ||
      out_data_o.field_z == 48'h7FFF_FFFF_FFFF || out_data_o.field_z == 48'h8000_0000_0000 ||
      out_data_o.potential == 48'h7FFF_FFFF_FFFF ||
      out_data_o.potential == 48'h8000_0000_0000)
    else $error("overflow without a saturated value");

  // An empty output slot never blocks the input
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with no output pending");

  // A waiting output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

endmodule

bind dipole_field_and_potential dpf_checker u_dpf_checker (.*);

### test/dipole_field_and_potential_tb.sv
module dipole_field_and_potential_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 250;
  localparam int NUM_RANDOM     = 1420;
  localparam logic [dpf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [dpf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;
  localparam longint unsigned UNIT_LOW = 64'd1 << 34;
  localparam longint unsigned POS_LIM  = (64'd1 << 47) - 64'd1;
  localparam longint unsigned NEG_LIM  = 64'd1 << 47;

  // Dipole predictor and store of pending field results
  class dipole_scoreboard;
    logic [31:0]    regs [6];
    dpf_pkg::out_t  pending [$];
    int             mismatches;
    int             results;
    int             singular_seen;
    int             overflow_seen;

    function new();
      foreach (regs[i]) regs[i] = '0;
      mismatches = 0;
      results = 0;
      singular_seen = 0;
      overflow_seen = 0;
    endfunction

    function void set_reg(logic [dpf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      if (idx <= dpf_pkg::CFG_MOMENT_Z) regs[idx] = val;
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Divide by the distance 'steps' times and place at the final binary point
    static function logic [47:0] scale_dist(longint x, longint unsigned n, int e,
                                            int steps, ref bit ov);
      longint unsigned q, lim, val;
      int z, sh;
      if (x == 0) return '0;
      q = (x < 0) ? -x : x;
      z = 0;
      while (q < UNIT_LOW) begin
        q <<= 1;
        z++;
      end
      for (int i = 0; i < steps; i++) q = (q << dpf_pkg::DIR_BITS) / n;
      if (q == 0) return '0;
      sh = steps * (e + dpf_pkg::FRAC_BITS - dpf_pkg::DIR_BITS) - z;
      lim = (x < 0) ? NEG_LIM : POS_LIM;
      if (sh >= 0) begin
        if (sh >= 48 || q > (lim >> sh)) begin
          ov = 1;
          val = lim;
        end else begin
          val = q << sh;
        end
      end else begin
        val = (-sh >= 64) ? 0 : (q >> (-sh));
      end
      return (x < 0) ? 48'(-val) : 48'(val);
    endfunction

    function dpf_pkg::out_t predict(dpf_pkg::in_t pt);
      dpf_pkg::out_t o;
      longint p [3], h [3], r, dot, c, u;
      longint unsigned rm [3], a, s, n, hm;
      bit rneg [3], ov;
      logic signed [31:0] coord [3];
      int e;
      coord[0] = pt.point_x;
      coord[1] = pt.point_y;
      coord[2] = pt.point_z;
      o = '0;
      a = 0;
      s = 0;
      e = 0;
      ov = 0;
      for (int i = 0; i < 3; i++) begin
        r = longint'(coord[i]) - longint'($signed(regs[i]));
        p[i] = longint'($signed(regs[3 + i]));
        rneg[i] = r < 0;
        rm[i] = rneg[i] ? -r : r;
        if (rm[i] > a) a = rm[i];
      end
      if (a == 0) begin
        o.singular = 1'b1;
        return o;
      end
      // normalize the largest offset into [2^29, 2^30)
      while (a >= (64'd1 << 30)) begin
        a >>= 1;
        e--;
      end
      while (a < (64'd1 << 29)) begin
        a <<= 1;
        e++;
      end
      for (int i = 0; i < 3; i++) begin
        rm[i] = (e < 0) ? (rm[i] >> (-e)) : (rm[i] << e);
        s += rm[i] * rm[i];
      end
      n = int_sqrt(s);
      dot = 0;
      for (int i = 0; i < 3; i++) begin
        hm = (rm[i] << dpf_pkg::DIR_BITS) / n;
        h[i] = rneg[i] ? -longint'(hm) : longint'(hm);
        dot += p[i] * h[i];
      end
      c = dot / (64'sd1 <<< dpf_pkg::DIR_BITS);
      u = (3 * c * h[0]) / (64'sd1 <<< dpf_pkg::DIR_BITS) - p[0];
      o.field_x = scale_dist(u, n, e, 3, ov);
      u = (3 * c * h[1]) / (64'sd1 <<< dpf_pkg::DIR_BITS) - p[1];
      o.field_y = scale_dist(u, n, e, 3, ov);
      u = (3 * c * h[2]) / (64'sd1 <<< dpf_pkg::DIR_BITS) - p[2];
      o.field_z = scale_dist(u, n, e, 3, ov);
      o.potential = scale_dist(c, n, e, 2, ov);
      o.overflow = ov;
      return o;
    endfunction

    function void note_point(dpf_pkg::in_t pt);
      pending.push_back(predict(pt));
    endfunction

    function void check_result(dpf_pkg::out_t got);
      dpf_pkg::out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      results++;
      if (want.singular) singular_seen++;
      if (want.overflow) overflow_seen++;
      if (got.field_x !== want.field_x || got.field_y !== want.field_y ||
          got.field_z !== want.field_z || got.potential !== want.potential ||
          got.singular !== want.singular || got.overflow !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch on result %0d:", results);
          $display("  exp E=(%0d,%0d,%0d) V=%0d sing=%b ovf=%b", want.field_x,
                   want.field_y, want.field_z, want.potential, want.singular,
                   want.overflow);
          $display("  got E=(%0d,%0d,%0d) V=%0d sing=%b ovf=%b", got.field_x,
                   got.field_y, got.field_z, got.potential, got.singular,
                   got.overflow);
        end
      end
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  dpf_pkg::in_t                   in_data_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  dpf_pkg::out_t                  out_data_o;
  logic                           cfg_we_i;
  logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [dpf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  dipole_scoreboard field_sb;
  bit   steady;          // when set, neither side idles
  int   ready_hold;
  int   quiet_cycles;
  int   points_sent;

  dipole_field_and_potential i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial field_sb = new();

  // Receive result beats and draw receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_hold  <= 0;
    end else begin
      if (out_valid_o && out_ready_i) field_sb.check_result(out_data_o);
      if (ready_hold > 0) begin
        out_ready_i <= 1'b0;
        ready_hold  <= ready_hold - 1;
      end else if (out_valid_o && out_ready_i) begin
        ready_hold  <= steady ? 0 : $urandom_range(0, 10);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog on beats in either direction
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, %0d results pending", field_sb.pending.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Drive one point beat; valid stays high across back-to-back beats
  task automatic send_point(dpf_pkg::in_t pt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= pt;
    do @(posedge clk_i); while (!in_ready_o);
    field_sb.note_point(pt);
    points_sent++;
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (field_sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [dpf_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    field_sb.set_reg(idx, val);
  endtask

  task automatic load_dipole(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [31:0] mx, logic [31:0] my, logic [31:0] mz);
    write_reg(dpf_pkg::CFG_CENTER_X, cx);
    write_reg(dpf_pkg::CFG_CENTER_Y, cy);
    write_reg(dpf_pkg::CFG_CENTER_Z, cz);
    write_reg(dpf_pkg::CFG_MOMENT_X, mx);
    write_reg(dpf_pkg::CFG_MOMENT_Y, my);
    write_reg(dpf_pkg::CFG_MOMENT_Z, mz);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mix of full-range points, points near the center and the center itself
  function automatic dpf_pkg::in_t pick_point();
    dpf_pkg::in_t pt;
    int  mode;
    logic [31:0] delta [3];
    mode = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(0, 3))
        0: delta[i] = 32'($signed($urandom_range(0, 16)) - 8);
        1: delta[i] = 32'($urandom_range(0, 32'hFFFF)) - 32'h8000;
        2: delta[i] = $urandom >> $urandom_range(0, 31);
        default: delta[i] = $urandom;
      endcase
    end
    if (mode < 40) begin
      pt = {$urandom, $urandom, $urandom};
    end else if (mode < 97) begin
      pt.point_x = field_sb.regs[0] + delta[0];
      pt.point_y = field_sb.regs[1] + delta[1];
      pt.point_z = field_sb.regs[2] + delta[2];
    end else begin
      pt = {field_sb.regs[0], field_sb.regs[1], field_sb.regs[2]};
    end
    return pt;
  endfunction

  initial begin
    dpf_pkg::in_t pt;
    steady      = 1'b0;
    points_sent = 0;
    quiet_cycles = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = dpf_pkg::CFG_CENTER_X;
    cfg_data_i  = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: zero moment, so every result is zero or singular
    send_point('0);
    send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001});
    drain();

    // Directed: moment in the y-z plane at the origin, then unused indexes
    load_dipole('0, '0, '0, 32'h0000_0000, 32'h0001_0000, 32'h0003_0000);
    write_reg(CFG_UNUSED_A, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED_B, 32'h1234_5678);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_point('0);
    send_point({32'h0000_0001, 32'h0, 32'h0});
    send_point({32'h0, 32'h0, 32'hFFFF_FFFF});
    send_point({32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_point({32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
    send_point({32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000});
    send_point({32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
    send_point({32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0010});
    send_point({32'h0, 32'h0, 32'h0100_0000});
    send_point({32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000});
    drain();

    // Extreme center and moment: widest offsets, saturating outputs
    load_dipole(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point({32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_point({32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFE});
    send_point({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000});
    send_point({32'h0, 32'h0, 32'h0});
    send_point({32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    drain();

    // Random phases with a fresh dipole each time, one of them without idling
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        load_dipole(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      end else if (ph == 0) begin
        load_dipole($urandom, $urandom, $urandom, 32'h0000_1000, 32'hFFFF_F000, 32'h0);
      end else begin
        load_dipole($urandom, $urandom, $urandom,
                    $urandom >> $urandom_range(0, 31), $urandom,
                    $urandom >> $urandom_range(0, 31));
      end
      steady = (ph == 2);
      for (int k = 0; k < NUM_RANDOM / 6; k++) begin
        pt = pick_point();
        send_point(pt);
      end
      steady = 1'b0;
      drain();
    end

    $display("covered %0d points, %0d results: %0d at the center, %0d saturated",
             points_sent, field_sb.results, field_sb.singular_seen,
             field_sb.overflow_seen);
    $display("dipole settings included reset, extremes and random, with mismatches=%0d",
             field_sb.mismatches);
    if (field_sb.mismatches == 0 && field_sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
